// ===== rtl/core/mini_isa_execute_unit_top_assert.svh =====
// Assertion macros for the mini ISA execute unit.
`ifndef MINI_ISA_EXECUTE_UNIT_TOP_ASSERT_SVH
`define MINI_ISA_EXECUTE_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MIEXU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("execute unit check failed");

// Next-cycle implication, disabled in reset.
`define MIEXU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("execute unit check failed");

`endif

// ===== rtl/core/miexu_pkg.sv =====
// Types and constants of the mini ISA execute unit.
package miexu_pkg;

	localparam int REG_COUNT_DEF = 32;
	localparam int DATA_W        = 64;
	localparam int IDX_W         = 5;
	localparam int OP_W          = 4;
	localparam int COND_W        = 3;
	localparam int SHAMT_W       = 6;

	typedef enum logic [OP_W-1:0] {
		OP_MOV    = 4'd0,
		OP_ADD    = 4'd1,
		OP_SUB    = 4'd2,
		OP_CMP    = 4'd3,
		OP_CMP_U  = 4'd4,
		OP_AND    = 4'd5,
		OP_ASR    = 4'd6,
		OP_EOR    = 4'd7,
		OP_LSL    = 4'd8,
		OP_LSR    = 4'd9,
		OP_ORR    = 4'd10,
		OP_BRANCH = 4'd11
	} op_t;

	typedef enum logic [COND_W-1:0] {
		COND_EQ     = 3'd0,
		COND_GE     = 3'd1,
		COND_GT     = 3'd2,
		COND_LT     = 3'd3,
		COND_LE     = 3'd4,
		COND_NE     = 3'd5,
		COND_ALWAYS = 3'd6
	} cond_t;

	typedef struct packed {
		logic [OP_W-1:0]          req_type;
		logic [IDX_W-1:0]         dest_reg;
		logic [IDX_W-1:0]         src_a_reg;
		logic [IDX_W-1:0]         src_b_reg;
		logic                     b_is_immediate;
		logic signed [DATA_W-1:0] immediate;
		logic [COND_W-1:0]        condition;
	} req_t;

	typedef struct packed {
		logic                     write_enable;
		logic signed [DATA_W-1:0] write_value;
		logic                     branch_taken;
		logic                     flag_greater;
		logic                     flag_equal;
		logic                     flag_less;
	} rsp_t;

endpackage

// ===== rtl/core/mini_isa_execute_unit_top.sv =====
// Top level of the mini ISA execute unit: register file, ALU, flags and output register.
// One decoded instruction per request is executed against REG_COUNT 64-bit registers and
// the greater/equal/less flags; every request yields exactly one response carrying the
// written value, the branch outcome and the flags afterwards. The unit takes one request
// per cycle while rsp_ready stays high. A request is read from the register file memory
// at the edge it is accepted (two read ports, registered data) into stage 1, is executed
// and written back as it moves into the output register, and its response then stays
// there until rsp_ready takes it. A write committed at the same edge a following
// request reads is bypassed from a last-write register. Registers start at zero after
// reset through one valid bit per entry; no clearing pass is needed. Register indexes at
// or above REG_COUNT read as zero and writes to them are dropped. The output register
// decouples the sides: one new request can be accepted into stage 1 while a finished
// response waits for rsp_ready.
module mini_isa_execute_unit_top #(
	parameter int REG_COUNT = miexu_pkg::REG_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  miexu_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output miexu_pkg::rsp_t  rsp
);
	import miexu_pkg::*;

	`include "mini_isa_execute_unit_top_assert.svh"

	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int IW = (AW > IDX_W) ? AW : IDX_W;

	// register file storage, valid bit per entry stands in for reset-to-zero
	logic [DATA_W-1:0]    mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;

	// stage 1: request plus registered read data
	logic              valid_s1;
	req_t              req_s1;
	logic [AW-1:0]     a_addr_s1;
	logic [AW-1:0]     b_addr_s1;
	logic [AW-1:0]     d_addr_s1;
	logic              a_ok_s1;
	logic              b_ok_s1;
	logic              d_ok_s1;
	logic              a_vld_s1;
	logic              b_vld_s1;
	logic [DATA_W-1:0] rd_a_s1;
	logic [DATA_W-1:0] rd_b_s1;

	// last committed write, for the bypass
	logic              lw_vld_q;
	logic [AW-1:0]     lw_addr_q;
	logic [DATA_W-1:0] lw_data_q;

	// architectural flags
	logic fg_q;
	logic fe_q;
	logic fl_q;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// handshake and index decode
	logic          req_acc;
	logic          adv;
	logic [IW:0]   a_ext;
	logic [IW:0]   b_ext;
	logic [IW:0]   d_ext;
	logic          a_ok;
	logic          b_ok;
	logic          d_ok;
	logic [AW-1:0] a_addr;
	logic [AW-1:0] b_addr;
	logic [AW-1:0] d_addr;

	// execute
	logic [DATA_W-1:0]  opa;
	logic [DATA_W-1:0]  opb_reg;
	logic [DATA_W-1:0]  opb;
	logic [DATA_W-1:0]  imm;
	logic [SHAMT_W-1:0] shamt;
	logic [DATA_W-1:0]  alu_val;
	logic               alu_wr;
	logic               taken;
	logic               is_cmp;
	logic               nx_g;
	logic               nx_e;
	logic               nx_l;
	logic               mem_we;
	rsp_t               rsp_d;

	// s1 moves on when the output register is free or being drained
	assign adv       = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign req_acc   = req_valid && req_ready;

	// indexes are widened before the range check so any REG_COUNT works
	assign a_ext  = (IW+1)'(req.src_a_reg);
	assign b_ext  = (IW+1)'(req.src_b_reg);
	assign d_ext  = (IW+1)'(req.dest_reg);
	assign a_ok   = a_ext < (IW+1)'(REG_COUNT);
	assign b_ok   = b_ext < (IW+1)'(REG_COUNT);
	assign d_ok   = d_ext < (IW+1)'(REG_COUNT);
	assign a_addr = a_ext[AW-1:0];
	assign b_addr = b_ext[AW-1:0];
	assign d_addr = d_ext[AW-1:0];

	// memory: write back from s1, read both sources at acceptance
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[d_addr_s1] <= alu_val;
		end
		if (req_acc) begin
			rd_a_s1 <= mem[a_addr];
			rd_b_s1 <= mem[b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[d_addr_s1] <= 1'b1;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1    <= req;
			a_addr_s1 <= a_addr;
			b_addr_s1 <= b_addr;
			d_addr_s1 <= d_addr;
			a_ok_s1   <= a_ok;
			b_ok_s1   <= b_ok;
			d_ok_s1   <= d_ok;
			a_vld_s1  <= a_ok && vld_q[a_addr];
			b_vld_s1  <= b_ok && vld_q[b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// operand select with bypass from the most recent write; an entry never
	// written reads as zero
	always_comb begin
		if (!a_ok_s1) begin
			opa = '0;
		end else if (lw_vld_q && (lw_addr_q == a_addr_s1)) begin
			opa = lw_data_q;
		end else if (a_vld_s1) begin
			opa = rd_a_s1;
		end else begin
			opa = '0;
		end

		if (!b_ok_s1) begin
			opb_reg = '0;
		end else if (lw_vld_q && (lw_addr_q == b_addr_s1)) begin
			opb_reg = lw_data_q;
		end else if (b_vld_s1) begin
			opb_reg = rd_b_s1;
		end else begin
			opb_reg = '0;
		end
	end

	assign imm   = req_s1.immediate;
	assign opb   = req_s1.b_is_immediate ? imm : opb_reg;
	assign shamt = imm[SHAMT_W-1:0];

	// ALU and branch evaluation
	always_comb begin
		alu_val = '0;
		alu_wr  = 1'b0;
		taken   = 1'b0;
		is_cmp  = 1'b0;
		nx_g    = fg_q;
		nx_e    = fe_q;
		nx_l    = fl_q;
		case (op_t'(req_s1.req_type))
			OP_MOV: begin
				alu_val = imm;
				alu_wr  = 1'b1;
			end
			OP_ADD: begin
				alu_val = opa + opb;
				alu_wr  = 1'b1;
			end
			OP_SUB: begin
				alu_val = opa - opb;
				alu_wr  = 1'b1;
			end
			OP_CMP: begin
				is_cmp = 1'b1;
				nx_g   = $signed(opa) > $signed(opb);
				nx_l   = $signed(opa) < $signed(opb);
				nx_e   = opa == opb;
			end
			OP_CMP_U: begin
				is_cmp = 1'b1;
				nx_g   = opa > opb;
				nx_l   = opa < opb;
				nx_e   = opa == opb;
			end
			OP_AND: begin
				alu_val = opa & opb_reg;
				alu_wr  = 1'b1;
			end
			OP_ASR: begin
				alu_val = DATA_W'($signed(opa) >>> shamt);
				alu_wr  = 1'b1;
			end
			OP_EOR: begin
				alu_val = opa ^ opb_reg;
				alu_wr  = 1'b1;
			end
			OP_LSL: begin
				alu_val = opa << shamt;
				alu_wr  = 1'b1;
			end
			OP_LSR: begin
				alu_val = opa >> shamt;
				alu_wr  = 1'b1;
			end
			OP_ORR: begin
				alu_val = opa | opb_reg;
				alu_wr  = 1'b1;
			end
			OP_BRANCH: begin
				case (cond_t'(req_s1.condition))
					COND_EQ: taken = fe_q;
					COND_GE: taken = fe_q || fg_q;
					COND_GT: taken = fg_q;
					COND_LT: taken = fl_q;
					COND_LE: taken = fl_q || fe_q;
					COND_NE: taken = !fe_q;
					// unused condition code behaves as always
					default: taken = 1'b1;
				endcase
			end
			// unused opcodes do nothing
			default: ;
		endcase
	end

	// out-of-range destination drops the write
	assign mem_we = adv && alu_wr && d_ok_s1;

	always_comb begin
		rsp_d.write_enable = alu_wr && d_ok_s1;
		rsp_d.write_value  = (alu_wr && d_ok_s1) ? alu_val : '0;
		rsp_d.branch_taken = taken;
		rsp_d.flag_greater = nx_g;
		rsp_d.flag_equal   = nx_e;
		rsp_d.flag_less    = nx_l;
	end

	// commit: flags and bypass register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q     <= 1'b0;
			fe_q     <= 1'b0;
			fl_q     <= 1'b0;
			lw_vld_q <= 1'b0;
		end else if (adv) begin
			fg_q <= nx_g;
			fe_q <= nx_e;
			fl_q <= nx_l;
			if (mem_we) begin
				lw_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lw_addr_q <= d_addr_s1;
			lw_data_q <= alu_val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// at most one flag set; exactly one after the first compare
	`MIEXU_ASSERT_NOW(a_flags_onehot0, 1'b1, $onehot0({fg_q, fe_q, fl_q}))
	// a response without a write carries a zero value
	`MIEXU_ASSERT_NOW(a_nowr_zero, rsp_valid && !rsp.write_enable, rsp.write_value == '0)
	// a response never both writes and branches
	`MIEXU_ASSERT_NOW(a_wr_xor_br, rsp_valid, !(rsp.write_enable && rsp.branch_taken))
	// flags only move on a committed compare
	`MIEXU_ASSERT_NEXT(a_flags_hold, !(adv && is_cmp), $stable({fg_q, fe_q, fl_q}))

endmodule

// ===== test/tb.sv =====
// Testbench for the mini ISA execute unit: directed table, random instructions, flag predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import miexu_pkg::*;

	// Register count follows the package default that the block is built with.
	localparam int REG_COUNT = REG_COUNT_DEF;

	// Request-type and condition codes that the package leaves unnamed.
	localparam logic [OP_W-1:0]   OP_UNDEF_LO = 4'd12;
	localparam logic [OP_W-1:0]   OP_UNDEF_HI = 4'd15;
	localparam logic [COND_W-1:0] COND_UNDEF  = 3'd7;

	localparam logic [DATA_W-1:0] IMM_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DATA_W-1:0] IMM_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [DATA_W-1:0] IMM_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam int RAND_N        = 1100;
	localparam int DRAIN_AT      = 600;    // sender waits for every response here
	localparam int STEADY_FROM   = 700;    // sender never idles and receiver adds no new stalls in this window
	localparam int STEADY_TO     = 850;
	localparam int HOLD_AT       = 300;    // receiver starts its long hold-off here
	localparam int HOLD_CYCLES   = 250;
	localparam int TAIL_CYCLES   = 10;
	localparam int CYCLE_LIMIT   = 300000;

	// One row of the directed table; pinned rows carry a hand-written response.
	typedef struct {
		req_t r;
		bit   pinned;
		rsp_t want;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Sidecar for the request on the bus: its pinned response, if any.
	bit   pin_valid = 1'b0;
	rsp_t pin_rsp   = '0;
	bit   steady    = 1'b0;

	// Predictor state: architectural registers and compare flags.
	logic [DATA_W-1:0] arch_regs [REG_COUNT];
	bit flag_gt, flag_eq, flag_lt;

	rsp_t     pending_rsp [$];
	dir_row_t directed [$];
	int       accepted_n = 0;
	int       errors     = 0;
	int       cycles     = 0;
	int       hold_left  = 0;
	bit       hold_done  = 1'b0;

	mini_isa_execute_unit_top #(.REG_COUNT(REG_COUNT)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Execute one instruction against the predictor state and return its response.
	function automatic rsp_t execute_instr(input req_t r);
		logic [DATA_W-1:0]  a, rb, b, val;
		logic [SHAMT_W-1:0] sh;
		bit   wr, taken;
		rsp_t o;
		a     = (r.src_a_reg < REG_COUNT) ? arch_regs[r.src_a_reg] : '0;
		rb    = (r.src_b_reg < REG_COUNT) ? arch_regs[r.src_b_reg] : '0;
		b     = r.b_is_immediate ? r.immediate : rb;
		sh    = r.immediate[SHAMT_W-1:0];
		val   = '0;
		wr    = 1'b0;
		taken = 1'b0;
		case (r.req_type)
			OP_MOV: begin
				val = r.immediate;
				wr  = 1'b1;
			end
			OP_ADD: begin
				val = a + b;
				wr  = 1'b1;
			end
			OP_SUB: begin
				val = a - b;
				wr  = 1'b1;
			end
			OP_CMP: begin
				flag_gt = $signed(a) > $signed(b);
				flag_lt = $signed(a) < $signed(b);
				flag_eq = !flag_gt && !flag_lt;
			end
			OP_CMP_U: begin
				flag_gt = a > b;
				flag_lt = a < b;
				flag_eq = !flag_gt && !flag_lt;
			end
			OP_AND: begin
				val = a & rb;
				wr  = 1'b1;
			end
			OP_ASR: begin
				val = $signed(a) >>> sh;
				wr  = 1'b1;
			end
			OP_EOR: begin
				val = a ^ rb;
				wr  = 1'b1;
			end
			OP_LSL: begin
				val = a << sh;
				wr  = 1'b1;
			end
			OP_LSR: begin
				val = a >> sh;
				wr  = 1'b1;
			end
			OP_ORR: begin
				val = a | rb;
				wr  = 1'b1;
			end
			OP_BRANCH: begin
				case (r.condition)
					COND_EQ: taken = flag_eq;
					COND_GE: taken = flag_eq || flag_gt;
					COND_GT: taken = flag_gt;
					COND_LT: taken = flag_lt;
					COND_LE: taken = flag_lt || flag_eq;
					COND_NE: taken = !flag_eq;
					default: taken = 1'b1;   // always, and the undefined code
				endcase
			end
			default: ;   // undefined request types do nothing
		endcase
		if (wr && r.dest_reg < REG_COUNT) begin
			arch_regs[r.dest_reg] = val;
		end else begin
			wr  = 1'b0;
			val = '0;
		end
		o.write_enable = wr;
		o.write_value  = val;
		o.branch_taken = taken;
		o.flag_greater = flag_gt;
		o.flag_equal   = flag_eq;
		o.flag_less    = flag_lt;
		return o;
	endfunction

	function automatic rsp_t fixed(input bit we, input logic [DATA_W-1:0] val,
			input bit tk, input bit g, input bit e, input bit l);
		rsp_t o;
		o.write_enable = we;
		o.write_value  = val;
		o.branch_taken = tk;
		o.flag_greater = g;
		o.flag_equal   = e;
		o.flag_less    = l;
		return o;
	endfunction

	function automatic dir_row_t row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] dst,
			input logic [IDX_W-1:0] sa, input logic [IDX_W-1:0] sb, input logic bimm,
			input logic [DATA_W-1:0] imm, input logic [COND_W-1:0] cond,
			input bit pinned, input rsp_t want);
		dir_row_t d;
		d.r.req_type       = op;
		d.r.dest_reg       = dst;
		d.r.src_a_reg      = sa;
		d.r.src_b_reg      = sb;
		d.r.b_is_immediate = bimm;
		d.r.immediate      = imm;
		d.r.condition      = cond;
		d.pinned           = pinned;
		d.want             = want;
		return d;
	endfunction

	// Half the picks are drawn from r0..r3 so back-to-back dependencies are common.
	function automatic logic [IDX_W-1:0] pick_reg();
		return $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 3))
			: IDX_W'($urandom_range(0, 31));
	endfunction

	function automatic logic [DATA_W-1:0] pick_imm();
		int s;
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 5))
			1: begin
				s = $urandom_range(0, 16);
				v = DATA_W'(s - 8);
			end
			2: begin
				case ($urandom_range(0, 3))
					0: v = IMM_MAX;
					1: v = IMM_MIN;
					2: v = '0;
					default: v = IMM_ONES;
				endcase
			end
			3: v = DATA_W'($urandom_range(0, 127));   // shift amounts past 63 too
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// Compares and branches are weighted up so flags change often and get tested.
	function automatic req_t rand_instr();
		req_t r;
		int k;
		k = $urandom_range(0, 19);
		if (k <= 11)
			r.req_type = k[OP_W-1:0];
		else if (k <= 13)
			r.req_type = OP_CMP;
		else if (k <= 15)
			r.req_type = OP_CMP_U;
		else if (k <= 17)
			r.req_type = OP_BRANCH;
		else
			r.req_type = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
		r.dest_reg       = pick_reg();
		r.src_a_reg      = pick_reg();
		r.src_b_reg      = pick_reg();
		r.b_is_immediate = 1'($urandom_range(0, 1));
		r.immediate      = pick_imm();
		r.condition      = COND_W'($urandom_range(0, 7));
		return r;
	endfunction

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		else if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic idle(input int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Present one request and hold it until the unit takes it.
	task automatic offer(input req_t r, input bit pinned, input rsp_t want);
		req_valid <= 1'b1;
		req       <= r;
		pin_valid <= pinned;
		pin_rsp   <= want;
		do @(posedge clk); while (!req_ready);
	endtask

	// Drop valid, let the last acceptance land in the queue, then wait it out.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Scoreboard: responses are checked before this edge's request is predicted.
	always @(posedge clk) begin
		rsp_t w;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: response with no request pending, actual %p", $time, rsp);
					errors++;
				end else begin
					w = pending_rsp.pop_front();
					check_field("write_enable", DATA_W'(w.write_enable),
						DATA_W'(rsp.write_enable));
					check_field("write_value",  w.write_value,  rsp.write_value);
					check_field("branch_taken", DATA_W'(w.branch_taken),
						DATA_W'(rsp.branch_taken));
					check_field("flag_greater", DATA_W'(w.flag_greater),
						DATA_W'(rsp.flag_greater));
					check_field("flag_equal",   DATA_W'(w.flag_equal),
						DATA_W'(rsp.flag_equal));
					check_field("flag_less",    DATA_W'(w.flag_less),
						DATA_W'(rsp.flag_less));
				end
			end
			if (req_valid && req_ready) begin
				// The predictor always runs so its state tracks pinned rows as well.
				w = execute_instr(req);
				pending_rsp.push_back(pin_valid ? pin_rsp : w);
				accepted_n <= accepted_n + 1;
			end
		end
	end

	// Response side: random stalls, one long hold-off to back the unit up,
	// and full throughput while the sender is in its steady window.
	always @(posedge clk) begin
		int p;
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (!hold_done && accepted_n >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			rsp_ready <= 1'b0;
		end else if (steady || !arst_n) begin
			rsp_ready <= 1'b1;
		end else begin
			p = $urandom_range(0, 99);
			if (p < 70) begin
				rsp_ready <= 1'b1;
			end else if (p < 95) begin
				hold_left <= $urandom_range(0, 2);
				rsp_ready <= 1'b0;
			end else begin
				hold_left <= $urandom_range(9, 39);
				rsp_ready <= 1'b0;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < REG_COUNT; i++)
			arch_regs[i] = '0;
		flag_gt = 1'b0;
		flag_eq = 1'b0;
		flag_lt = 1'b0;

		// Directed table. Reset state: registers zero, all flags clear.
		// Flags clear means eq fails, ne holds, and the undefined code acts as always.
		directed.push_back(row(OP_BRANCH, 0, 0, 0, 0, '0, COND_EQ, 1, fixed(0, '0, 0, 0, 0, 0)));
		directed.push_back(row(OP_BRANCH, 0, 0, 0, 0, '0, COND_UNDEF, 1,
			fixed(0, '0, 1, 0, 0, 0)));
		// Undefined request types write nothing even with a live destination.
		directed.push_back(row(OP_UNDEF_LO, 3, 1, 2, 1, IMM_ONES, COND_ALWAYS, 1,
			fixed(0, '0, 0, 0, 0, 0)));
		directed.push_back(row(OP_UNDEF_HI, 4, 0, 0, 0, IMM_MAX, COND_ALWAYS, 1,
			fixed(0, '0, 0, 0, 0, 0)));
		directed.push_back(row(OP_ADD, 3, 0, 0, 0, IMM_ONES, COND_EQ, 1, fixed(1, '0, 0, 0, 0, 0)));
		directed.push_back(row(OP_MOV, 1, 0, 0, 0, IMM_MAX, COND_EQ, 1,
			fixed(1, IMM_MAX, 0, 0, 0, 0)));
		directed.push_back(row(OP_MOV, 2, 0, 0, 0, IMM_MIN, COND_EQ, 1,
			fixed(1, IMM_MIN, 0, 0, 0, 0)));
		directed.push_back(row(OP_MOV, 4, 0, 0, 0, IMM_ONES, COND_EQ, 1,
			fixed(1, IMM_ONES, 0, 0, 0, 0)));
		directed.push_back(row(OP_MOV, 5, 0, 0, 0, 64'd1, COND_EQ, 1, fixed(1, 64'd1, 0, 0, 0, 0)));
		directed.push_back(row(OP_BRANCH, 0, 0, 0, 0, '0, COND_NE, 1, fixed(0, '0, 1, 0, 0, 0)));
		// Wrapping add/sub at both ends of the signed range.
		directed.push_back(row(OP_ADD, 6, 1, 5, 0, '0, COND_EQ, 0, '0));
		directed.push_back(row(OP_SUB, 7, 2, 0, 1, 64'd1, COND_EQ, 0, '0));
		directed.push_back(row(OP_SUB, 8, 0, 5, 0, '0, COND_EQ, 0, '0));
		// Signed and unsigned compares disagree on max versus min.
		directed.push_back(row(OP_CMP, 0, 1, 2, 0, '0, COND_EQ, 0, '0));
		directed.push_back(row(OP_BRANCH, 0, 0, 0, 0, '0, COND_GT, 0, '0));
		directed.push_back(row(OP_CMP_U, 0, 1, 2, 0, '0, COND_EQ, 0, '0));
		directed.push_back(row(OP_BRANCH, 0, 0, 0, 0, '0, COND_LE, 0, '0));
		directed.push_back(row(OP_BRANCH, 0, 0, 0, 0, '0, COND_LT, 0, '0));
		directed.push_back(row(OP_CMP, 0, 4, 0, 1, IMM_ONES, COND_EQ, 0, '0));
		directed.push_back(row(OP_BRANCH, 0, 0, 0, 0, '0, COND_GE, 0, '0));
		directed.push_back(row(OP_CMP_U, 0, 4, 5, 0, '0, COND_EQ, 0, '0));
		directed.push_back(row(OP_BRANCH, 0, 0, 0, 0, '0, COND_EQ, 0, '0));
		// Logic ops take B from the register even with the immediate flag set.
		directed.push_back(row(OP_AND, 9, 4, 1, 1, '0, COND_EQ, 0, '0));
		directed.push_back(row(OP_EOR, 10, 4, 2, 1, IMM_ONES, COND_EQ, 0, '0));
		directed.push_back(row(OP_ORR, 11, 2, 5, 0, '0, COND_EQ, 0, '0));
		// Shifts use only the low six bits of the immediate.
		directed.push_back(row(OP_ASR, 12, 2, 0, 0, IMM_ONES, COND_EQ, 0, '0));
		directed.push_back(row(OP_ASR, 13, 1, 0, 0, 64'd67, COND_EQ, 0, '0));
		directed.push_back(row(OP_LSL, 14, 4, 0, 0, 64'd63, COND_EQ, 0, '0));
		directed.push_back(row(OP_LSR, 15, 4, 0, 0, 64'd127, COND_EQ, 0, '0));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			idle(pick_gap());
			offer(directed[i].r, directed[i].pinned, directed[i].want);
		end

		for (int i = 0; i < RAND_N; i++) begin
			// Let the pipeline empty out completely once mid-run.
			if (i == DRAIN_AT)
				drain();
			steady <= (i >= STEADY_FROM) && (i < STEADY_TO);
			if (!(i >= STEADY_FROM && i < STEADY_TO))
				idle(pick_gap());
			offer(rand_instr(), 1'b0, '0);
		end

		drain();
		steady <= 1'b0;
		// TAIL_CYCLES spare cycles catch any stray response.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
